// ----- rtl/core/psgtn_pkg.sv -----
// ----------------------------------------------------------------------------
// psgtn_pkg
// shared widths, codes, attenuation table and controller/datapath bundles
// ----------------------------------------------------------------------------
package psgtn_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int STEP_W        = 16;
	localparam int HP_W          = 27;
	localparam int REG_W         = 10;
	localparam int NIB_W         = 4;
	localparam int VOL_W         = 14;
	localparam int SHIFT_W       = 17;
	localparam int V_W           = 24;
	localparam int ACC_W         = 40;
	localparam int CH_N          = 3;
	localparam int CH_W          = 2;

	localparam logic [STEP_W-1:0]  STEP_RESET   = 16'd15052;
	localparam logic [SHIFT_W-1:0] FB_WHITE     = 17'h14002;
	localparam logic [SHIFT_W-1:0] FB_PERIODIC  = 17'h08000;
	localparam logic [SHIFT_W-1:0] SHIFT_PRESET = 17'h00f35;

	typedef enum logic [1:0] {
		KIND_TONE  = 2'd0,
		KIND_NOISE = 2'd1,
		KIND_TICK  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	localparam logic [2:0] REG_TONE2     = 3'd4;
	localparam logic [2:0] REG_NOISE_CTL = 3'd6;
	localparam logic [2:0] REG_NOISE_VOL = 3'd7;

	localparam logic [CH_W-1:0] CH_LAST = 2'd2;

	// 2 dB per step, last step silent
	function automatic logic [VOL_W-1:0] atten_lut(input logic [NIB_W-1:0] idx);
		logic [VOL_W-1:0] v;
		unique case (idx)
			4'd0:  v = 14'd10922;
			4'd1:  v = 14'd8675;
			4'd2:  v = 14'd6891;
			4'd3:  v = 14'd5473;
			4'd4:  v = 14'd4348;
			4'd5:  v = 14'd3453;
			4'd6:  v = 14'd2743;
			4'd7:  v = 14'd2179;
			4'd8:  v = 14'd1731;
			4'd9:  v = 14'd1374;
			4'd10: v = 14'd1092;
			4'd11: v = 14'd867;
			4'd12: v = 14'd689;
			4'd13: v = 14'd547;
			4'd14: v = 14'd434;
			4'd15: v = 14'd0;
		endcase
		return v;
	endfunction

	typedef struct packed {
		logic load_in;
		logic do_write;
		logic do_period;
		logic tone_init;
		logic div_start;
		logic tone_mul;
		logic tone_upd;
		logic tone_acc;
		logic noise_init;
		logic noise_step;
		logic noise_acc;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_write;
		logic is_tick;
		logic per_needed;
		logic div_done;
		logic last_ch;
		logic noise_silent;
		logic noise_done;
	} sts_t;

endpackage

// ----- rtl/core/psg_tone_noise_synth.sv -----
// ----------------------------------------------------------------------------
// psg_tone_noise_synth
// two-set square-wave and noise sound generator with a 16-bit-style mixer
// ----------------------------------------------------------------------------
//  channel   signals                         transfer when
//  in        in_valid, in_stall, kind, data  in_valid && !in_stall
//  out       out_valid, out_stall, sample    out_valid && !out_stall
//  cfg       cfg_we, cfg_wdata               cfg_we
//
//  a register byte is decoded and written, then a period step (multiply)
//  follows when it sets a period register; a sample tick runs each of the
//  three tone channels through the shared divider, multiply, update and
//  accumulate; a channel whose count outlasts the sample skips the
//  divider; the noise shifter then steps once per noise event inside the
//  sample, plus a final step when the sample ends between events, none
//  while silent
//  a finished sample sits in the output register; the next item is taken
//  while it waits, and a later tick holds until that register is free
//  reset and a cfg write both bring every channel back to its start state
// ----------------------------------------------------------------------------
module psg_tone_noise_synth #(
	parameter int FRAC_BITS = psgtn_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   kind,
	input  logic [7:0]                   data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [14:0]                  sample,
	input  logic                         cfg_we,
	input  logic [psgtn_pkg::STEP_W-1:0] cfg_wdata
);
	import psgtn_pkg::*;

	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	// sequencer: one item in flight, result handoff through out_valid
	psgtn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// register sets, tone math, noise shifter, mixer and output register
	psgtn_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.kind      (kind),
		.data      (data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.sample    (sample)
	);

endmodule

// ----- rtl/core/psgtn_div.sv -----
// ----------------------------------------------------------------------------
// psgtn_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module psgtn_div #(
	parameter int DW = 16,
	parameter int VW = 27
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] quot,
	output logic [VW-1:0] rem
);
	localparam int CW = $clog2(DW + 1);

	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [DW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [VW:0]   trial;
	logic [VW:0]   diff;
	logic          ge;

	assign trial = {rem_q, quo_q[DW-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

// ----- rtl/core/psgtn_ctrl.sv -----
// ----------------------------------------------------------------------------
// psgtn_ctrl
// sequencer: byte writes, tone channel passes, noise events, result handoff
// ----------------------------------------------------------------------------
module psgtn_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  psgtn_pkg::sts_t  sts,
	output psgtn_pkg::cmd_t  cmd
);
	import psgtn_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_DEC  = 13'b0000000000010,
		S_WR   = 13'b0000000000100,
		S_PER  = 13'b0000000001000,
		S_TSET = 13'b0000000010000,
		S_TDIV = 13'b0000000100000,
		S_TMUL = 13'b0000001000000,
		S_TUPD = 13'b0000010000000,
		S_TACC = 13'b0000100000000,
		S_NSET = 13'b0001000000000,
		S_NRUN = 13'b0010000000000,
		S_NACC = 13'b0100000000000,
		S_OUT  = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.is_write) begin
					state_d = S_WR;
				end else if (sts.is_tick) begin
					cmd.tone_init = 1'b1;
					state_d       = S_TSET;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_WR: begin
				cmd.do_write = 1'b1;
				state_d      = sts.per_needed ? S_PER : S_IDLE;
			end
			S_PER: begin
				cmd.do_period = 1'b1;
				state_d       = S_IDLE;
			end
			S_TSET: begin
				cmd.div_start = 1'b1;
				state_d       = S_TDIV;
			end
			S_TDIV: begin
				if (sts.div_done)
					state_d = S_TMUL;
			end
			S_TMUL: begin
				cmd.tone_mul = 1'b1;
				state_d      = S_TUPD;
			end
			S_TUPD: begin
				cmd.tone_upd = 1'b1;
				state_d      = S_TACC;
			end
			S_TACC: begin
				cmd.tone_acc = 1'b1;
				state_d      = sts.last_ch ? S_NSET : S_TSET;
			end
			S_NSET: begin
				cmd.noise_init = 1'b1;
				state_d        = sts.noise_silent ? S_NACC : S_NRUN;
			end
			S_NRUN: begin
				cmd.noise_step = 1'b1;
				if (sts.noise_done)
					state_d = S_NACC;
			end
			S_NACC: begin
				cmd.noise_acc = 1'b1;
				state_d       = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- rtl/core/psgtn_dp.sv -----
// ----------------------------------------------------------------------------
// psgtn_dp
// register sets, period multiply, tone high-time math, noise shifter, mixer
// ----------------------------------------------------------------------------
module psgtn_dp #(
	parameter int FRAC_BITS = psgtn_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [1:0]                      kind,
	input  logic [7:0]                      data,
	input  logic                            cfg_we,
	input  logic [psgtn_pkg::STEP_W-1:0]    cfg_wdata,
	input  psgtn_pkg::cmd_t                 cmd,
	output psgtn_pkg::sts_t                 sts,
	output logic [14:0]                     sample
);
	import psgtn_pkg::*;

	localparam int SW     = FRAC_BITS + 1;
	localparam int VS_W   = HP_W + 4;
	localparam int NACC_W = SW + VOL_W;
	localparam int PM_W   = REG_W + STEP_W;
	localparam logic [SW-1:0]    STEP_ONE = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [HP_W-1:0]  STEP_HP  = HP_W'(STEP_ONE);
	localparam logic [ACC_W-1:0] PART_MAX =
		{{(ACC_W - 15 - FRAC_BITS){1'b0}}, 15'h7fff, {FRAC_BITS{1'b0}}};
	localparam logic [V_W-1:0]   V_MAX    = {V_W{1'b1}};

	// captured item
	logic [1:0]        kind_q;
	logic [7:0]        data_q;

	logic [STEP_W-1:0] step_q;

	// tone set
	logic [REG_W-1:0]  t_reg_q [CH_N];
	logic [HP_W-1:0]   t_hp_q  [CH_N];
	logic [HP_W-1:0]   t_cnt_q [CH_N];
	logic              t_lvl_q [CH_N];
	logic [NIB_W-1:0]  t_vol_q [CH_N];
	logic [2:0]        t_latch_q;

	// noise set
	logic [2:0]        n_latch_q;
	logic [REG_W-1:0]  n_reg4_q;
	logic [NIB_W-1:0]  n_ctl_q;
	logic [HP_W-1:0]   n_hp2_q;
	logic [HP_W-1:0]   n_hp3_q;
	logic [HP_W-1:0]   n_cnt_q;
	logic              n_lvl_q;
	logic [SHIFT_W-1:0] n_shift_q;
	logic              n_armed_q;
	logic [NIB_W-1:0]  n_vol_q;

	// sequencing scratch
	logic [2:0]        per_r_q;
	logic [CH_W-1:0]   ch_q;
	logic              skip_q;
	logic [HP_W:0]     prod_q;
	logic [V_W-1:0]    vclamp_q;
	logic [ACC_W-1:0]  tacc_q;
	logic [SW-1:0]     left_q;
	logic [SW-1:0]     nv_q;
	logic [NACC_W-1:0] nacc_q;
	logic [14:0]       sample_q;

	// byte decode
	logic              wr_noise;
	logic              latch_byte;
	logic [2:0]        r_new;
	logic [NIB_W-1:0]  nib;
	logic [2:0]        r_eff;
	logic              per_needed;
	logic [STEP_W-1:0] step_n;
	logic [HP_W-1:0]   mode_hp3;

	assign wr_noise   = (kind_q == KIND_NOISE);
	assign latch_byte = data_q[7];
	assign r_new      = data_q[6:4];
	assign nib        = data_q[3:0];
	assign r_eff      = latch_byte ? r_new : (wr_noise ? n_latch_q : t_latch_q);
	assign per_needed = !r_eff[0] && (r_eff != REG_NOISE_CTL);
	assign step_n     = (cfg_wdata == '0) ? STEP_W'(1) : cfg_wdata;
	assign mode_hp3   = (nib[1:0] == 2'b11) ? {n_hp2_q[HP_W-2:0], 1'b0}
	                                        : HP_W'(step_q) << (3'd5 + {1'b0, nib[1:0]});

	// period from register value
	logic [REG_W-1:0]  per_reg;
	logic [PM_W-1:0]   per_prod;
	logic [HP_W-1:0]   per_p;

	assign per_reg  = wr_noise ? n_reg4_q : t_reg_q[per_r_q[2:1]];
	assign per_prod = step_q * per_reg;
	assign per_p    = (per_prod == '0) ? HP_W'(step_q) : HP_W'(per_prod);

	// tone channel
	logic [HP_W-1:0]      cur_hp;
	logic [HP_W-1:0]      cur_cnt;
	logic                 cur_lvl;
	logic                 skip_now;
	logic [FRAC_BITS-1:0] d_now;
	logic                 div_busy;
	logic [FRAC_BITS-1:0] quot;
	logic [HP_W-1:0]      rem;
	logic [HP_W+FRAC_BITS-2:0] half_prod;
	logic                 q_odd;
	logic                 new_lvl;
	logic [HP_W-1:0]      cnt_new;
	logic [HP_W-1:0]      base;
	logic [HP_W-1:0]      extra;
	logic [HP_W-1:0]      sub;
	logic [VS_W-1:0]      vsum;
	logic [V_W-1:0]       vclamp;

	assign cur_hp   = t_hp_q[ch_q];
	assign cur_cnt  = t_cnt_q[ch_q];
	assign cur_lvl  = t_lvl_q[ch_q];
	assign skip_now = cur_cnt > STEP_HP;
	assign d_now    = FRAC_BITS'(STEP_HP - cur_cnt);

	psgtn_div #(
		.DW (FRAC_BITS),
		.VW (HP_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start && !skip_now),
		.dividend (d_now),
		.divisor  (cur_hp),
		.busy     (div_busy),
		.quot     (quot),
		.rem      (rem)
	);

	assign half_prod = cur_hp * quot[FRAC_BITS-1:1];

	// whole periods that fit the sample, then the final partial half period; a skipped channel holds its level all sample
	always_comb begin
		q_odd = quot[0];
		base  = cur_lvl ? cur_cnt : '0;
		if (skip_q) begin
			new_lvl = cur_lvl;
			cnt_new = cur_cnt - STEP_HP;
			extra   = '0;
			sub     = '0;
			vsum    = cur_lvl ? VS_W'(STEP_ONE) : '0;
		end else begin
			new_lvl = q_odd ? cur_lvl : !cur_lvl;
			cnt_new = cur_hp - rem;
			extra   = (q_odd || new_lvl) ? cur_hp : '0;
			sub     = new_lvl ? cnt_new : '0;
			vsum    = VS_W'(base) + VS_W'(prod_q) + VS_W'(extra) - VS_W'(sub);
		end
		if (vsum[VS_W-1])
			vclamp = '0;
		else if (vsum > VS_W'(V_MAX))
			vclamp = V_MAX;
		else
			vclamp = vsum[V_W-1:0];
	end

	// noise channel
	logic [VOL_W-1:0]   n_vol_val;
	logic [SHIFT_W-1:0] fb;
	logic [SHIFT_W-1:0] shift_x;
	logic [SHIFT_W-1:0] shift_n;
	logic               n_event;

	assign n_vol_val = atten_lut(n_vol_q);
	assign fb        = !n_armed_q ? '0 : (n_ctl_q[2] ? FB_WHITE : FB_PERIODIC);
	assign shift_x   = n_shift_q[0] ? (n_shift_q ^ fb) : n_shift_q;
	assign shift_n   = shift_x >> 1;
	assign n_event   = n_cnt_q <= HP_W'(left_q);

	// mixer
	logic [14:0] tsat;
	logic [14:0] nsat;
	logic [15:0] mix;

	assign tsat = (tacc_q > PART_MAX) ? 15'h7fff : tacc_q[FRAC_BITS+14:FRAC_BITS];
	// noise part alone stays below the clamp level
	assign nsat = nacc_q[FRAC_BITS+14:FRAC_BITS];
	assign mix  = {1'b0, tsat} + {1'b0, nsat};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= STEP_RESET;
			for (int i = 0; i < CH_N; i++) begin
				t_reg_q[i] <= '0;
				t_hp_q[i]  <= HP_W'(STEP_RESET);
				t_cnt_q[i] <= HP_W'(STEP_RESET);
				t_lvl_q[i] <= 1'b0;
				t_vol_q[i] <= '1;
			end
			t_latch_q <= '0;
			n_latch_q <= '0;
			n_reg4_q  <= '0;
			n_ctl_q   <= '0;
			n_hp2_q   <= HP_W'(STEP_RESET);
			n_hp3_q   <= HP_W'(STEP_RESET);
			n_cnt_q   <= HP_W'(STEP_RESET);
			n_lvl_q   <= 1'b0;
			n_shift_q <= '0;
			n_armed_q <= 1'b0;
			n_vol_q   <= '1;
			ch_q      <= '0;
		end else if (cfg_we) begin
			step_q    <= step_n;
			for (int i = 0; i < CH_N; i++) begin
				t_reg_q[i] <= '0;
				t_hp_q[i]  <= HP_W'(step_n);
				t_cnt_q[i] <= HP_W'(step_n);
				t_lvl_q[i] <= 1'b0;
				t_vol_q[i] <= '1;
			end
			t_latch_q <= '0;
			n_latch_q <= '0;
			n_reg4_q  <= '0;
			n_ctl_q   <= '0;
			n_hp2_q   <= HP_W'(step_n);
			n_hp3_q   <= HP_W'(step_n);
			n_cnt_q   <= HP_W'(step_n);
			n_lvl_q   <= 1'b0;
			n_shift_q <= '0;
			n_armed_q <= 1'b0;
			n_vol_q   <= '1;
			ch_q      <= '0;
		end else begin
			if (cmd.do_write) begin
				if (wr_noise) begin
					if (latch_byte) begin
						n_latch_q <= r_new;
						if (r_new == REG_TONE2) begin
							n_reg4_q[3:0] <= nib;
						end else if (r_new == REG_NOISE_CTL) begin
							n_ctl_q   <= nib;
							n_armed_q <= 1'b1;
							n_hp3_q   <= mode_hp3;
							n_shift_q <= SHIFT_PRESET;
							n_lvl_q   <= SHIFT_PRESET[0];
						end else if (r_new == REG_NOISE_VOL) begin
							n_vol_q <= nib;
						end
					end else if (n_latch_q == REG_TONE2) begin
						n_reg4_q[REG_W-1:4] <= data_q[5:0];
					end
				end else begin
					if (latch_byte) begin
						t_latch_q <= r_new;
						if (!r_new[0] && r_new != REG_NOISE_CTL)
							t_reg_q[r_new[2:1]][3:0] <= nib;
						else if (r_new[0] && r_new != REG_NOISE_VOL)
							t_vol_q[r_new[2:1]] <= nib;
					end else if (per_needed) begin
						t_reg_q[t_latch_q[2:1]][REG_W-1:4] <= data_q[5:0];
					end
				end
			end
			if (cmd.do_period) begin
				if (wr_noise) begin
					if (per_r_q == REG_TONE2) begin
						n_hp2_q <= per_p;
						if (n_ctl_q[1:0] == 2'b11)
							n_hp3_q <= {per_p[HP_W-2:0], 1'b0};
					end
				end else begin
					t_hp_q[per_r_q[2:1]] <= per_p;
				end
			end
			if (cmd.tone_init)
				ch_q <= '0;
			if (cmd.tone_upd) begin
				t_cnt_q[ch_q] <= cnt_new;
				t_lvl_q[ch_q] <= new_lvl;
			end
			if (cmd.tone_acc)
				ch_q <= ch_q + 1'b1;
			if (cmd.noise_step) begin
				if (n_event) begin
					n_shift_q <= shift_n;
					n_lvl_q   <= shift_n[0];
					n_cnt_q   <= n_hp3_q;
				end else begin
					n_cnt_q <= n_cnt_q - HP_W'(left_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q <= kind;
			data_q <= data;
		end
		if (cmd.do_write)
			per_r_q <= r_eff;
		if (cmd.tone_init)
			tacc_q <= '0;
		if (cmd.div_start)
			skip_q <= skip_now;
		if (cmd.tone_mul)
			prod_q <= (HP_W + 1)'(half_prod);
		if (cmd.tone_upd)
			vclamp_q <= vclamp;
		if (cmd.tone_acc)
			tacc_q <= tacc_q + ACC_W'(vclamp_q * atten_lut(t_vol_q[ch_q]));
		if (cmd.noise_init) begin
			left_q <= STEP_ONE;
			nv_q   <= '0;
		end
		if (cmd.noise_step) begin
			if (n_event) begin
				nv_q   <= nv_q + (n_lvl_q ? SW'(n_cnt_q) : '0);
				left_q <= left_q - SW'(n_cnt_q);
			end else begin
				nv_q   <= nv_q + (n_lvl_q ? left_q : '0);
				left_q <= '0;
			end
		end
		if (cmd.noise_acc)
			nacc_q <= nv_q * n_vol_val;
		if (cmd.out_load)
			sample_q <= mix[15:1];
	end

	assign sts.is_write     = (kind_q == KIND_TONE) || (kind_q == KIND_NOISE);
	assign sts.is_tick      = (kind_q == KIND_TICK);
	assign sts.per_needed   = per_needed;
	assign sts.div_done     = skip_q || !div_busy;
	assign sts.last_ch      = (ch_q == CH_LAST);
	assign sts.noise_silent = (n_vol_val == '0);
	assign sts.noise_done   = n_event ? (n_cnt_q == HP_W'(left_q)) : 1'b1;

	assign sample = sample_q;

endmodule

// ----- tb/psg_tone_noise_synth_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psg_tone_noise_synth_tb
// self-checking bench for the two-set tone and noise generator: a directed
// table, then random register bytes and sample ticks over several step
// settings, with random idling on both channels and every sample checked
// against a behavioral model of the channels and mixer
// ----------------------------------------------------------------------------
module psg_tone_noise_synth_tb;
	import psgtn_pkg::*;

	localparam longint ONE_SAMPLE = longint'(1) << FRAC_BITS_DEF;
	localparam longint PART_CLAMP = longint'(16'h7fff) << FRAC_BITS_DEF;
	localparam int     CYCLE_LIMIT = 20000000;
	localparam int     DRAIN_CYCLES = 40;
	localparam int     HOLD_CYCLES = 400;
	localparam int     NO_CHECK = -1;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [1:0]          kind = KIND_NONE;
	logic [7:0]          data = 8'h00;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [14:0]         sample;
	logic                cfg_we = 1'b0;
	logic [STEP_W-1:0]   cfg_wdata = '0;

	psg_tone_noise_synth DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.data     (data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample   (sample),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- model
	// per set: index 0 is the tone set, 1 the noise set
	int unsigned step_size;
	int unsigned regs [2][8];
	int unsigned half_per [2][4];
	longint      phase [2][4];
	bit          level [2][4];
	int unsigned vol [2][4];
	int unsigned shifter [2];
	bit          white [2];
	bit          taps_on [2];
	int unsigned latched [2];

	function automatic int unsigned atten_gain(input int unsigned idx);
		int unsigned gains [16];
		gains = '{10922, 8675, 6891, 5473, 4348, 3453, 2743, 2179,
			1731, 1374, 1092, 867, 689, 547, 434, 0};
		return gains[idx];
	endfunction

	function automatic void clear_channels();
		for (int s = 0; s < 2; s++) begin
			for (int i = 0; i < 8; i++)
				regs[s][i] = (i % 2) ? 15 : 0;
			for (int i = 0; i < 4; i++) begin
				half_per[s][i] = step_size;
				phase[s][i] = step_size;
				level[s][i] = 0;
				vol[s][i] = 0;
			end
			shifter[s] = 0;
			white[s] = 0;
			taps_on[s] = 0;
			latched[s] = 0;
		end
	endfunction

	function automatic void load_period(input int s, input int unsigned r);
		int unsigned p;
		p = step_size * regs[s][r];
		if (p == 0)
			p = step_size;
		half_per[s][r >> 1] = p;
		// periodic/white noise following channel 2 tracks its period
		if (r == REG_TONE2 && (regs[s][REG_NOISE_CTL] & 3) == 3)
			half_per[s][3] = half_per[s][2] << 1;
	endfunction

	function automatic void write_reg_byte(input int s, input int unsigned d);
		int unsigned r;
		int unsigned n;
		if (d & 8'h80) begin
			r = (d >> 4) & 7;
			latched[s] = r;
			regs[s][r] = (regs[s][r] & 10'h3f0) | (d & 4'hf);
			if (r == 0 || r == 2 || r == REG_TONE2) begin
				load_period(s, r);
			end else if (r == REG_NOISE_CTL) begin
				n = regs[s][r];
				white[s] = (n >> 2) & 1;
				taps_on[s] = 1;
				n = n & 3;
				half_per[s][3] = (n == 3) ? (half_per[s][2] << 1) : (step_size << (5 + n));
				shifter[s] = SHIFT_PRESET;
				level[s][3] = SHIFT_PRESET[0];
			end else begin
				vol[s][r >> 1] = atten_gain(d & 4'hf);
			end
		end else begin
			r = latched[s];
			if (r == 0 || r == 2 || r == REG_TONE2) begin
				regs[s][r] = (regs[s][r] & 4'hf) | ((d & 6'h3f) << 4);
				load_period(s, r);
			end
		end
	endfunction

	function automatic int unsigned tone_mix();
		longint unsigned acc;
		longint v, p, cnt;
		acc = 0;
		for (int i = 0; i < CH_N; i++) begin
			v = 0;
			p = half_per[0][i];
			cnt = phase[0][i];
			if (level[0][i])
				v += cnt;
			cnt -= ONE_SAMPLE;
			while (cnt <= 0) begin
				cnt += p;
				if (cnt > 0) begin
					level[0][i] ^= 1'b1;
					if (level[0][i])
						v += p;
					break;
				end
				cnt += p;
				v += p;
			end
			if (level[0][i])
				v -= cnt;
			phase[0][i] = cnt;
			if (v < 0)
				v = 0;
			acc += longint'(v) * vol[0][i];
		end
		if (acc > PART_CLAMP)
			acc = PART_CLAMP;
		return acc >> FRAC_BITS_DEF;
	endfunction

	function automatic int unsigned noise_mix();
		longint unsigned acc;
		longint v, p, cnt, left, nxt;
		int unsigned fb;
		v = 0;
		// a silent noise channel does not advance at all
		if (vol[1][3] != 0) begin
			fb = taps_on[1] ? (white[1] ? FB_WHITE : FB_PERIODIC) : 0;
			p = half_per[1][3];
			cnt = phase[1][3];
			left = ONE_SAMPLE;
			do begin
				nxt = (cnt < left) ? cnt : left;
				if (nxt < 1)
					nxt = 1;
				if (level[1][3])
					v += cnt;
				cnt -= nxt;
				if (cnt <= 0) begin
					if (shifter[1] & 1)
						shifter[1] ^= fb;
					shifter[1] = (shifter[1] >> 1) & 17'h1ffff;
					level[1][3] = shifter[1] & 1;
					cnt += p;
					if (level[1][3])
						v += p;
				end
				if (level[1][3])
					v -= cnt;
				left -= nxt;
			end while (left > 0);
			phase[1][3] = cnt;
		end
		if (v < 0)
			v = 0;
		acc = longint'(v) * vol[1][3];
		if (acc > PART_CLAMP)
			acc = PART_CLAMP;
		return acc >> FRAC_BITS_DEF;
	endfunction

	// ------------------------------------------------------------- checking
	int  sample_q [$];
	int  errors = 0;
	int  samples_seen = 0;
	int  bytes_sent = 0;
	int  ticks_sent = 0;
	int  cycles = 0;
	int  idle_mode = 0;
	bit  hold_req = 0;
	int  hold_left = 0;

	// one accepted transfer on the input: update the model, queue a sample for a tick
	function automatic void model_transfer(input logic [1:0] k, input logic [7:0] d,
			input int typed);
		int unsigned t, n, s;
		case (k)
			KIND_TONE, KIND_NOISE: begin
				write_reg_byte(k, d);
				bytes_sent++;
			end
			KIND_TICK: begin
				t = tone_mix();
				n = noise_mix();
				s = ((t + n) >> 1) & 15'h7fff;
				if (typed != NO_CHECK && typed != s) begin
					$display("%0t: table value %0d disagrees with model %0d", $time, typed, s);
					errors++;
				end
				sample_q.push_back(s);
				ticks_sent++;
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("psg_tone_noise_synth: mismatch");
			$finish;
		end
		if (out_valid && !out_stall) begin
			if (sample_q.size() == 0) begin
				$display("%0t: unexpected sample, actual %0d", $time, sample);
				errors++;
			end else begin
				if (sample !== sample_q[0][14:0]) begin
					$display("%0t: sample expected %0d actual %0d", $time, sample_q[0], sample);
					errors++;
				end
				void'(sample_q.pop_front());
			end
			samples_seen++;
		end
	end

	// receiver: random stall, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left = HOLD_CYCLES;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (idle_mode)
				0: out_stall <= ($urandom_range(0, 99) < 82);
				1: out_stall <= ($urandom_range(0, 99) < 15);
				default: out_stall <= 1'b0;
			endcase
		end
	end

	// ------------------------------------------------------------- stimulus
	task automatic send_item(input logic [1:0] k, input logic [7:0] d, input int typed);
		int gap_pct;
		gap_pct = (idle_mode == 0) ? 15 : (idle_mode == 1) ? 82 : 0;
		@(negedge clk);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		data <= d;
		do
			@(posedge clk);
		while (in_stall);
		model_transfer(k, d, typed);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sample_q.size() != 0)
			@(posedge clk);
		// trailing register bytes may still be in flight
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_step(input logic [STEP_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		step_size = (value == 0) ? 1 : value;
		clear_channels();
	endtask

	// random byte or tick, weighted so the noise channel is often audible
	task automatic random_item();
		int pick;
		logic [7:0] d;
		pick = $urandom_range(0, 99);
		d = 8'($urandom);
		if (pick < 38) begin
			send_item(KIND_TICK, d, NO_CHECK);
		end else if (pick < 41) begin
			send_item(KIND_NONE, d, NO_CHECK);
		end else if (pick < 71) begin
			send_item(KIND_TONE, d, NO_CHECK);
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				d = {4'hf, 1'b0, d[2:0]};
			else if (pick < 50)
				d = {4'he, d[3:0]};
			send_item(KIND_NOISE, d, NO_CHECK);
		end
	endtask

	typedef struct {
		logic [1:0] k;
		logic [7:0] d;
		int         typed;
	} row_t;

	row_t rows [$];
	int   step_list [6];
	int   count_list [6];

	initial begin
		// silent tick after reset, tone set periods at the extremes, then the
		// noise set from no taps through white and periodic to silent
		rows = '{
			'{KIND_TICK, 8'h00, 0},
			'{KIND_NONE, 8'hff, NO_CHECK},
			'{KIND_TONE, 8'h90, NO_CHECK},
			'{KIND_TONE, 8'h8f, NO_CHECK},
			'{KIND_TONE, 8'h3f, NO_CHECK},
			'{KIND_TICK, 8'hff, NO_CHECK},
			'{KIND_TONE, 8'ha0, NO_CHECK},
			'{KIND_TONE, 8'hb5, NO_CHECK},
			'{KIND_TONE, 8'hc1, NO_CHECK},
			'{KIND_TONE, 8'h00, NO_CHECK},
			'{KIND_TONE, 8'hdf, NO_CHECK},
			'{KIND_TICK, 8'h00, NO_CHECK},
			'{KIND_TONE, 8'he7, NO_CHECK},
			'{KIND_TONE, 8'hf0, NO_CHECK},
			'{KIND_TONE, 8'h55, NO_CHECK},
			'{KIND_NOISE, 8'hf0, NO_CHECK},
			'{KIND_TICK, 8'h00, NO_CHECK},
			'{KIND_NOISE, 8'he4, NO_CHECK},
			'{KIND_TICK, 8'h00, NO_CHECK},
			'{KIND_NOISE, 8'hc2, NO_CHECK},
			'{KIND_NOISE, 8'h01, NO_CHECK},
			'{KIND_NOISE, 8'he3, NO_CHECK},
			'{KIND_TICK, 8'h00, NO_CHECK},
			'{KIND_NOISE, 8'hff, NO_CHECK},
			'{KIND_TICK, 8'h00, NO_CHECK}
		};
		step_list = '{STEP_RESET, 65535, 0, 1, $urandom_range(256, 65534),
			$urandom_range(1024, 65534)};
		// tiny steps make very short noise periods, so keep those phases short
		count_list = '{380, 380, 40, 40, 400, 410};

		step_size = STEP_RESET;
		clear_channels();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i])
			send_item(rows[i].k, rows[i].d, rows[i].typed);

		for (int ph = 0; ph < 6; ph++) begin
			settle();
			write_step(STEP_W'(step_list[ph]));
			idle_mode = (ph < 2) ? 0 : (ph < 4) ? 1 : 2;
			// long receiver hold-off so the block backs up into its input
			if (ph == 4)
				hold_req = 1;
			for (int i = 0; i < count_list[ph]; i++)
				random_item();
		end
		settle();

		$display("covered %0d register bytes and %0d sample ticks, %0d samples received",
			bytes_sent, ticks_sent, samples_seen);
		$display("step settings: reset, 65535, 0, 1 and two random values");
		if (errors == 0 && sample_q.size() == 0) begin
			$display("psg_tone_noise_synth: match");
		end else begin
			$display("%0d errors, %0d samples outstanding", errors, sample_q.size());
			$display("psg_tone_noise_synth: mismatch");
		end
		$finish;
	end

endmodule
